@@ hdl/tlfr_pkg.sv @@
`default_nettype none

package tlfr_pkg;

    // Phase codes of the deframer
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TAG  = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    // Byte classification
    localparam logic [2:0] K_SKIP    = 3'd0;
    localparam logic [2:0] K_START   = 3'd1;
    localparam logic [2:0] K_TAG_OK  = 3'd2;
    localparam logic [2:0] K_TAG_BAD = 3'd3;
    localparam logic [2:0] K_PAYLOAD = 3'd4;
    localparam logic [2:0] K_GOOD    = 3'd5;
    localparam logic [2:0] K_DISCARD = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] R_START_BYTE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_END_BYTE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_MASK_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_MASK_MID_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_MASK_MID_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] R_MASK_HIGH     = 3'd5;

    localparam logic [7:0] START_BYTE_RST = 8'd2;
    localparam logic [7:0] END_BYTE_RST   = 8'd3;
    localparam logic [7:0] MIN_TAG        = 8'd3;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  position;
        logic [2:0]  kind;
        logic [15:0] discard_count;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/tlfr_deframe.sv @@
`default_nettype none

module tlfr_deframe
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tlfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data,
    input  wire logic                           step,
    input  wire logic [7:0]                     rx_byte,
    output tlfr_pkg::result_t                   result
);

    logic [7:0]   start_byte_reg;
    logic [7:0]   end_byte_reg;
    logic [255:0] tag_mask_reg;

    logic [1:0]   phase_reg;
    logic [1:0]   phase_next;
    logic [7:0]   pos_reg;
    logic [7:0]   pos_next;
    logic [7:0]   len_reg;
    logic [7:0]   len_next;
    logic [15:0]  discards_reg;
    logic [15:0]  discards_next;

    logic         tag_ok;
    logic         last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= tlfr_pkg::START_BYTE_RST;
            end_byte_reg   <= tlfr_pkg::END_BYTE_RST;
            tag_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlfr_pkg::R_START_BYTE:    start_byte_reg        <= cfg_data[7:0];
                tlfr_pkg::R_END_BYTE:      end_byte_reg          <= cfg_data[7:0];
                tlfr_pkg::R_MASK_LOW:      tag_mask_reg[63:0]    <= cfg_data;
                tlfr_pkg::R_MASK_MID_LOW:  tag_mask_reg[127:64]  <= cfg_data;
                tlfr_pkg::R_MASK_MID_HIGH: tag_mask_reg[191:128] <= cfg_data;
                tlfr_pkg::R_MASK_HIGH:     tag_mask_reg[255:192] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign tag_ok    = (rx_byte >= tlfr_pkg::MIN_TAG) && tag_mask_reg[rx_byte];
    assign last_byte = (pos_reg == (len_reg - 8'd1));

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        discards_next = discards_reg;
        result.data     = rx_byte;
        result.position = pos_reg;
        result.kind     = tlfr_pkg::K_SKIP;

        case (phase_reg)
            tlfr_pkg::PH_TAG:
            begin
                if (tag_ok)
                begin
                    phase_next  = tlfr_pkg::PH_RECV;
                    len_next    = rx_byte;
                    pos_next    = pos_reg + 8'd1;
                    result.kind = tlfr_pkg::K_TAG_OK;
                end
                else
                begin
                    len_next    = '0;
                    result.kind = tlfr_pkg::K_TAG_BAD;
                end
            end
            tlfr_pkg::PH_RECV:
            begin
                if (last_byte)
                begin
                    if (rx_byte != end_byte_reg)
                    begin
                        discards_next = discards_reg + 16'd1;
                        result.kind   = tlfr_pkg::K_DISCARD;
                    end
                    else
                    begin
                        result.kind = tlfr_pkg::K_GOOD;
                    end
                    phase_next = tlfr_pkg::PH_HUNT;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next    = pos_reg + 8'd1;
                    result.kind = tlfr_pkg::K_PAYLOAD;
                end
            end
            default:
            begin
                // hunt, and the unused code acts the same
                result.position = '0;
                if (rx_byte == start_byte_reg)
                begin
                    phase_next  = tlfr_pkg::PH_TAG;
                    pos_next    = 8'd1;
                    result.kind = tlfr_pkg::K_START;
                end
                else
                begin
                    phase_next  = tlfr_pkg::PH_HUNT;
                    pos_next    = '0;
                    result.kind = tlfr_pkg::K_SKIP;
                end
            end
        endcase

        result.discard_count = discards_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tlfr_pkg::PH_HUNT;
            pos_reg      <= '0;
            len_reg      <= '0;
            discards_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            discards_reg <= discards_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tagged_length_frame_receiver.sv @@
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------------
// input    | in        | in_valid / in_stall   | rx_byte[7:0]
// result   | out       | out_valid / out_stall | out_byte, position, kind, discard_count
// config   | in        | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[63:0]
//
// One byte is accepted per cycle while in_stall is low; its result is registered into the
// output register when that stage is free, else into the skid register.
// The deframer state advances in the accept cycle, so the next byte may follow at once.
// A one-entry skid register behind the output register absorbs a stall; in_stall is
// the skid-full flag. Reset (rst_n, async low) empties both stages and loads the
// register defaults. cfg_ready is always high.

module tagged_length_frame_receiver
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     rx_byte,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          out_byte,
    output logic [7:0]                          position,
    output logic [2:0]                          kind,
    output logic [15:0]                         discard_count,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tlfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data
);

    tlfr_pkg::result_t result;
    tlfr_pkg::result_t out_reg;
    tlfr_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              accept;
    logic              take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign take      = out_valid_reg && !out_stall;

    tlfr_deframe u_deframe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .rx_byte   (rx_byte),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            // output stage free: refill from skid first, else from the new transaction
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_reg.data;
    assign position      = out_reg.position;
    assign kind          = out_reg.kind;
    assign discard_count = out_reg.discard_count;

endmodule

`default_nettype wire
